>>> design/pobs_pkg.sv
// Shared types and constants for the pulse oximeter beat/SpO2 core.
// Holds the configuration register map, its reset values and the queue depth.
// No dependencies.
`default_nettype none

package pobs_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BEAT_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BEAT_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AC_SWING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPO2_OFFSET       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPO2_SLOPE        = 3'd6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Integer quotient bits produced by the divider; a larger SpO2 ratio saturates
    localparam int INT_QBITS = 16;

    typedef struct packed {
        logic [17:0] finger_level;
        logic [15:0] min_beat_interval;
        logic [15:0] max_beat_interval;
        logic [15:0] signal_timeout;
        logic [17:0] min_ac_swing;
        logic [7:0]  spo2_offset;
        logic [7:0]  spo2_slope;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        finger_level:      18'd30000,
        min_beat_interval: 16'd300,
        max_beat_interval: 16'd2000,
        signal_timeout:    16'd2000,
        min_ac_swing:      18'd100,
        spo2_offset:       8'd110,
        spo2_slope:        8'd25
    };

endpackage

`default_nettype wire

>>> design/pobs_div.sv
// Restoring divider, one quotient bit per cycle, fixed-point quotient.
// Depends on pobs_pkg (INT_QBITS). Caller guarantees num >> INT_QBITS < den.
`default_nettype none

module pobs_div #(
    parameter int NUM_W  = 55,
    parameter int FRAC_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [pobs_pkg::INT_QBITS+FRAC_W-1:0] quot
);
    import pobs_pkg::*;

    localparam int QW    = INT_QBITS + FRAC_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [QW-1:0]    sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W:0] trial;
    logic [NUM_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(QW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift dividend bits out at the top, quotient bits in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num >> INT_QBITS;
            sh_reg  <= {num[INT_QBITS-1:0], {FRAC_W{1'b0}}};
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
            sh_reg  <= {sh_reg[QW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = sh_reg;

endmodule

`default_nettype wire

>>> design/pobs_front.sv
// Front part: accepts sample items, marks finger presence, queues them.
// Depends on pobs_pkg (QUEUE_DEPTH).
`default_nettype none

module pobs_front #(
    parameter int SAMPLE_BITS = 18
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [17:0]            finger_level,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] ir_sample,
    input  wire logic [SAMPLE_BITS-1:0] red_sample,
    input  wire logic [31:0]            time_ms,
    output logic                        q_valid,
    input  wire logic                   q_pop,
    output logic [SAMPLE_BITS-1:0]      q_ir,
    output logic [SAMPLE_BITS-1:0]      q_red,
    output logic [31:0]                 q_time,
    output logic                        q_present
);
    import pobs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;

    logic [SAMPLE_BITS-1:0] ir_mem   [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] red_mem  [QUEUE_DEPTH];
    logic [31:0]            time_mem [QUEUE_DEPTH];
    logic                   pres_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic push;
    logic present;

    assign present  = CMP_W'(ir_sample) > CMP_W'(finger_level);
    assign in_stall = count_reg == CNT_W'(QUEUE_DEPTH);
    assign push     = in_valid && !in_stall;
    assign q_valid  = count_reg != '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            count_next = count_reg + 1'b1;
        else if (!push && q_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ir_mem[wr_ptr_reg]   <= ir_sample;
            red_mem[wr_ptr_reg]  <= red_sample;
            time_mem[wr_ptr_reg] <= time_ms;
            pres_mem[wr_ptr_reg] <= present;
        end
    end

    assign q_ir      = ir_mem[rd_ptr_reg];
    assign q_red     = red_mem[rd_ptr_reg];
    assign q_time    = time_mem[rd_ptr_reg];
    assign q_present = pres_mem[rd_ptr_reg];

endmodule

`default_nettype wire

>>> design/pobs_back.sv
// Back part: sequencer that runs the DC/AC filters, peak and beat tracking,
// rate and SpO2 estimates for one queued item. Depends on pobs_pkg, pobs_div.
`default_nettype none

module pobs_back #(
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pobs_pkg::cfg_t         cfg,
    input  wire logic                   q_valid,
    output logic                        q_pop,
    input  wire logic [SAMPLE_BITS-1:0] q_ir,
    input  wire logic [SAMPLE_BITS-1:0] q_red,
    input  wire logic [31:0]            q_time,
    input  wire logic                   q_present,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  bpm,
    output logic [6:0]                  spo2,
    output logic                        finger_present,
    output logic                        beat,
    output logic                        signal_lost,
    output logic signed [19:0]          filtered_ir
);
    import pobs_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int XW   = S + F;
    localparam int AW   = S + F + 2;
    localparam int PW   = (AW > F + 18) ? AW : F + 18;
    localparam int DFW  = PW + 1;
    localparam int TW   = AW - 1;
    localparam int DROP = (S + F > 31) ? S + F - 31 : 0;
    localparam int MA   = DFW - DROP;
    localparam int MB   = XW - DROP;
    localparam int NW   = MA + MB;
    localparam int QW   = INT_QBITS + F;
    localparam int RW   = QW + 1;
    localparam int BW   = 8 + F;
    localparam int SPW  = 7 + F;
    localparam int CLW  = RW + 10;

    localparam int ONE       = 1 << F;
    localparam int HALF      = ONE / 2;
    localparam int KEEP_DC   = ((95 << F) + 50) / 100;
    localparam int KEEP_THR  = ((92 << F) + 50) / 100;
    localparam int KEEP_BPM  = ((70 << F) + 50) / 100;
    localparam int KEEP_SPO2 = ((80 << F) + 50) / 100;

    localparam longint PEAK_INIT_L = longint'(99999) << F;
    localparam logic signed [PW-1:0] PEAK_HI_INIT = PW'(-PEAK_INIT_L);
    localparam logic signed [PW-1:0] PEAK_LO_INIT = PW'(PEAK_INIT_L);
    localparam logic [TW-1:0]  THR_INIT  = TW'(1500 * ONE);
    localparam logic [BW-1:0]  BPM_INIT  = BW'(75 * ONE);
    localparam logic [SPW-1:0] SPO2_INIT = SPW'(98 * ONE);
    localparam logic signed [CLW-1:0] SPO2_HI = CLW'(100 * ONE);
    localparam logic signed [CLW-1:0] SPO2_LO = CLW'(70 * ONE);
    localparam logic signed [AW-1:0] SHOW_MAX = AW'(524287);
    localparam logic signed [AW-1:0] SHOW_MIN = AW'(-524288);
    localparam logic [NW-1:0] BPM_NUM = NW'(60000);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DC   = 4'd1;
    localparam logic [3:0] ST_AC   = 4'd2;
    localparam logic [3:0] ST_PEAK = 4'd3;
    localparam logic [3:0] ST_BDIV = 4'd4;
    localparam logic [3:0] ST_MULA = 4'd5;
    localparam logic [3:0] ST_MULB = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_SDIV = 4'd8;
    localparam logic [3:0] ST_CAL  = 4'd9;
    localparam logic [3:0] ST_CLP  = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;

    logic [3:0] state_reg, state_next;

    // Item being worked on
    logic [S-1:0] ir_reg, red_reg;
    logic [31:0]  time_reg;
    logic         pres_reg;

    // Filter and tracker state
    logic [XW-1:0]        dc_ir_reg, dc_red_reg;
    logic signed [AW-1:0] prev_ir_reg, prev_red_reg;
    logic signed [AW-1:0] ac_ir_reg, ac_red_reg;
    logic signed [PW-1:0] ir_hi_reg, ir_lo_reg, red_hi_reg, red_lo_reg;
    logic [TW-1:0]        thr_reg;
    logic                 latch_reg;
    logic [31:0]          last_beat_reg, last_pres_reg;
    logic [BW-1:0]        bpm_avg_reg;
    logic [SPW-1:0]       spo2_avg_reg;
    logic                 trig_reg, beat_ok_reg;

    // SpO2 datapath
    logic [NW-1:0]   prod_num_reg, prod_den_reg;
    logic [RW-1:0]   ratio_reg;
    logic [RW+7:0]   sprod_reg;

    // Result register
    logic        out_valid_reg;
    logic [7:0]  bpm_reg;
    logic [6:0]  spo2_reg;
    logic        present_reg;
    logic        beat_reg;
    logic        lost_reg;
    logic [19:0] filt_reg;

    // Divider
    logic          div_start, div_busy, div_done;
    logic [NW-1:0] div_num, div_den;
    logic [QW-1:0] div_quot;

    // ---------------- filters ----------------
    logic [XW-1:0]      x_ir, x_red;
    logic [XW+F+1:0]    dc_ir_sum, dc_red_sum;
    logic signed [AW:0] ac_ir_sum, ac_red_sum;

    assign x_ir  = XW'(ir_reg) << F;
    assign x_red = XW'(red_reg) << F;

    assign dc_ir_sum = (XW+F+2)'(dc_ir_reg) * (XW+F+2)'(KEEP_DC)
                     + (XW+F+2)'(x_ir) * (XW+F+2)'(ONE - KEEP_DC) + (XW+F+2)'(HALF);
    assign dc_red_sum = (XW+F+2)'(dc_red_reg) * (XW+F+2)'(KEEP_DC)
                      + (XW+F+2)'(x_red) * (XW+F+2)'(ONE - KEEP_DC) + (XW+F+2)'(HALF);

    assign ac_ir_sum = $signed((AW+1)'(x_ir)) - $signed((AW+1)'(dc_ir_reg))
                     + (AW+1)'(prev_ir_reg);
    assign ac_red_sum = $signed((AW+1)'(x_red)) - $signed((AW+1)'(dc_red_reg))
                      + (AW+1)'(prev_red_reg);

    // ---------------- peaks and beat ----------------
    logic signed [PW-1:0] ac_ir_p, ac_red_p;
    logic                 ac_gt_thr, ac_lt_thr, trig;
    logic [31:0]          interval;
    logic                 in_range;

    assign ac_ir_p   = PW'(ac_ir_reg);
    assign ac_red_p  = PW'(ac_red_reg);
    assign ac_gt_thr = ac_ir_reg > $signed({1'b0, thr_reg});
    assign ac_lt_thr = ac_ir_reg < $signed({1'b0, thr_reg});
    assign trig      = pres_reg && ac_gt_thr && !latch_reg;
    assign interval  = time_reg - last_beat_reg;
    assign in_range  = (interval > 32'(cfg.min_beat_interval))
                    && (interval < 32'(cfg.max_beat_interval));

    // ---------------- rate ----------------
    logic [BW-1:0]     rate;
    logic [BW+F+1:0]   bpm_sum;

    assign rate = (div_quot[QW-1:BW] != '0) ? {BW{1'b1}} : div_quot[BW-1:0];
    assign bpm_sum = (BW+F+2)'(bpm_avg_reg) * (BW+F+2)'(KEEP_BPM)
                   + (BW+F+2)'(rate) * (BW+F+2)'(ONE - KEEP_BPM) + (BW+F+2)'(HALF);

    // ---------------- SpO2 ----------------
    logic signed [DFW-1:0] ir_ac_s, red_ac_s;
    logic [DFW-1:0]        ir_ac, red_ac;
    logic [17+F:0]         swing;
    logic                  spo2_go;
    logic [MA-1:0]         mul_a;
    logic [MB-1:0]         mul_b;
    logic                  ratio_ovf;
    logic signed [CLW-1:0] calc;
    logic [SPW-1:0]        calc_c;
    logic [SPW+F+1:0]      spo2_sum;

    assign ir_ac_s  = DFW'(ir_hi_reg) - DFW'(ir_lo_reg);
    assign red_ac_s = DFW'(red_hi_reg) - DFW'(red_lo_reg);
    assign ir_ac    = ir_ac_s;
    assign red_ac   = red_ac_s;
    assign swing    = {cfg.min_ac_swing, {F{1'b0}}};
    assign spo2_go  = (ir_ac > swing) && (red_ac > swing)
                   && (dc_ir_reg != '0) && (dc_red_reg != '0);

    // One multiplier, shared by the numerator and denominator products
    assign mul_a = (state_reg == ST_MULA) ? MA'(red_ac >> DROP) : MA'(ir_ac >> DROP);
    assign mul_b = (state_reg == ST_MULA) ? MB'(dc_ir_reg >> DROP) : MB'(dc_red_reg >> DROP);

    assign ratio_ovf = {{INT_QBITS{1'b0}}, prod_num_reg} >= {prod_den_reg, {INT_QBITS{1'b0}}};

    assign calc = $signed(CLW'({cfg.spo2_offset, {F{1'b0}}})) - $signed(CLW'(sprod_reg));
    always_comb
    begin
        if (calc > SPO2_HI)
            calc_c = SPW'(SPO2_HI);
        else if (calc < SPO2_LO)
            calc_c = SPW'(SPO2_LO);
        else
            calc_c = SPW'(calc);
    end
    assign spo2_sum = (SPW+F+2)'(spo2_avg_reg) * (SPW+F+2)'(KEEP_SPO2)
                    + (SPW+F+2)'(calc_c) * (SPW+F+2)'(ONE - KEEP_SPO2) + (SPW+F+2)'(HALF);

    // ---------------- finish ----------------
    logic [TW-1:0]        mag;
    logic [TW+F+1:0]      thr_sum;
    logic signed [AW-1:0] shown;
    logic [19:0]          shown_sat;
    logic                 emit_ok;

    assign mag = ac_ir_reg[AW-1] ? TW'(-ac_ir_reg) : TW'(ac_ir_reg);
    assign thr_sum = (TW+F+2)'(thr_reg) * (TW+F+2)'(KEEP_THR)
                   + (TW+F+2)'(mag) * (TW+F+2)'(ONE - KEEP_THR) + (TW+F+2)'(HALF);
    assign shown = ac_ir_reg >>> F;
    always_comb
    begin
        if (shown > SHOW_MAX)
            shown_sat = SHOW_MAX[19:0];
        else if (shown < SHOW_MIN)
            shown_sat = SHOW_MIN[19:0];
        else
            shown_sat = shown[19:0];
    end
    assign emit_ok = !out_valid_reg || !out_stall;

    // ---------------- sequencer ----------------
    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = BPM_NUM;
        div_den   = NW'(interval);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_DC;
            ST_DC:   state_next = ST_AC;
            ST_AC:   state_next = ST_PEAK;
            ST_PEAK:
            begin
                if (trig && in_range)
                begin
                    div_start  = 1'b1;
                    state_next = ST_BDIV;
                end
                else
                    state_next = ST_FIN;
            end
            ST_BDIV: if (div_done) state_next = spo2_go ? ST_MULA : ST_FIN;
            ST_MULA: state_next = ST_MULB;
            ST_MULB: state_next = ST_CHK;
            ST_CHK:
            begin
                div_num = prod_num_reg;
                div_den = prod_den_reg;
                if (prod_den_reg == '0)
                    state_next = ST_FIN;
                else if (ratio_ovf)
                    state_next = ST_CAL;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV: if (div_done) state_next = ST_CAL;
            ST_CAL:  state_next = ST_CLP;
            ST_CLP:  state_next = ST_FIN;
            ST_FIN:  if (emit_ok) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dc_ir_reg     <= '0;
            dc_red_reg    <= '0;
            prev_ir_reg   <= '0;
            prev_red_reg  <= '0;
            ir_hi_reg     <= PEAK_HI_INIT;
            ir_lo_reg     <= PEAK_LO_INIT;
            red_hi_reg    <= PEAK_HI_INIT;
            red_lo_reg    <= PEAK_LO_INIT;
            thr_reg       <= THR_INIT;
            latch_reg     <= 1'b0;
            last_beat_reg <= '0;
            last_pres_reg <= '0;
            bpm_avg_reg   <= BPM_INIT;
            spo2_avg_reg  <= SPO2_INIT;
            trig_reg      <= 1'b0;
            beat_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_DC:
                begin
                    dc_ir_reg  <= dc_ir_sum[XW+F-1:F];
                    dc_red_reg <= dc_red_sum[XW+F-1:F];
                end
                ST_AC:
                begin
                    prev_ir_reg  <= ac_ir_sum[AW:1];
                    prev_red_reg <= ac_red_sum[AW:1];
                end
                ST_PEAK:
                begin
                    trig_reg    <= trig;
                    beat_ok_reg <= trig && in_range;
                    if (pres_reg)
                    begin
                        if (ac_ir_p > ir_hi_reg)   ir_hi_reg  <= ac_ir_p;
                        if (ac_ir_p < ir_lo_reg)   ir_lo_reg  <= ac_ir_p;
                        if (ac_red_p > red_hi_reg) red_hi_reg <= ac_red_p;
                        if (ac_red_p < red_lo_reg) red_lo_reg <= ac_red_p;
                    end
                end
                ST_BDIV:
                begin
                    if (div_done)
                        bpm_avg_reg <= bpm_sum[BW+F-1:F];
                end
                ST_CLP:
                begin
                    spo2_avg_reg <= spo2_sum[SPW+F-1:F];
                end
                ST_FIN:
                begin
                    if (emit_ok)
                    begin
                        // Trigger: record the time, restart the extremes
                        if (trig_reg)
                        begin
                            last_beat_reg <= time_reg;
                            ir_hi_reg     <= PEAK_HI_INIT;
                            ir_lo_reg     <= PEAK_LO_INIT;
                            red_hi_reg    <= PEAK_HI_INIT;
                            red_lo_reg    <= PEAK_LO_INIT;
                        end
                        // Arm the latch on a trigger; drop it with no finger or below threshold
                        latch_reg <= pres_reg && !ac_lt_thr && (trig_reg || latch_reg);
                        if (!pres_reg)
                        begin
                            bpm_avg_reg  <= BPM_INIT;
                            spo2_avg_reg <= SPO2_INIT;
                        end
                        else
                            last_pres_reg <= time_reg;
                        thr_reg <= thr_sum[TW+F-1:F];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ir_reg   <= q_ir;
            red_reg  <= q_red;
            time_reg <= q_time;
            pres_reg <= q_present;
        end
        if (state_reg == ST_AC)
        begin
            ac_ir_reg  <= ac_ir_sum[AW:1];
            ac_red_reg <= ac_red_sum[AW:1];
        end
        if (state_reg == ST_MULA)
            prod_num_reg <= NW'(mul_a) * NW'(mul_b);
        if (state_reg == ST_MULB)
            prod_den_reg <= NW'(mul_a) * NW'(mul_b);
        if (state_reg == ST_CHK && ratio_ovf)
            ratio_reg <= RW'(1) << QW;
        if (state_reg == ST_SDIV && div_done)
            ratio_reg <= RW'(div_quot);
        if (state_reg == ST_CAL)
            sprod_reg <= (RW+8)'(cfg.spo2_slope) * (RW+8)'(ratio_reg);
        if (state_reg == ST_FIN && emit_ok)
        begin
            bpm_reg     <= pres_reg ? bpm_avg_reg[BW-1:F] : BPM_INIT[BW-1:F];
            spo2_reg    <= pres_reg ? spo2_avg_reg[SPW-1:F] : SPO2_INIT[SPW-1:F];
            present_reg <= pres_reg;
            beat_reg    <= beat_ok_reg;
            lost_reg    <= !pres_reg && ((time_reg - last_pres_reg) > 32'(cfg.signal_timeout));
            filt_reg    <= shown_sat;
        end
    end

    pobs_div #(
        .NUM_W  (NW),
        .FRAC_W (F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid      = out_valid_reg;
    assign bpm            = bpm_reg;
    assign spo2           = spo2_reg;
    assign finger_present = present_reg;
    assign beat           = beat_reg;
    assign signal_lost    = lost_reg;
    assign filtered_ir    = $signed(filt_reg);

`ifndef SYNTHESIS
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BDIV || state_reg == ST_SDIV) |-> (div_busy || div_done))
        else $error("divider idle while sequencer waits on it");

    a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
        (spo2_avg_reg >= SPW'(70 * ONE)) && (spo2_avg_reg <= SPW'(100 * ONE)))
        else $error("smoothed SpO2 left the clamp range");

    a_beat_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && beat_ok_reg) |-> pres_reg)
        else $error("beat accepted without a finger");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_DC))
        else $error("popped item not taken into the filters");
`endif

endmodule

`default_nettype wire

>>> design/pulse_oximeter_beat_spo2_core.sv
// Top level of the pulse oximeter beat/SpO2 core: configuration registers,
// front (accept, classify, queue) and back (sequenced arithmetic).
// Depends on pobs_pkg, pobs_front, pobs_back (which uses pobs_div).
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  config   | cfg_we               | cfg_index, cfg_data (no read-back)
//  input    | in_valid / in_stall  | ir_sample, red_sample, time_ms
//  output   | out_valid / out_stall| bpm, spo2, finger_present, beat,
//           |                      | signal_lost, filtered_ir
//
// Steps per item with no beat: pop, DC, AC, peak/trigger, finish.
// A valid beat adds one rate division; an SpO2 update then adds two products,
// a check, a second division (skipped when the ratio saturates) and the
// calibrate and clamp steps.
// Both divisions use the one shared restoring divider.
// Reset: asynchronous, active low; restores configuration, control and estimator state.
// Stalls: a two-entry queue accepts items while the back part works until it
// is full, and the result register holds one item while out_stall is high.
`default_nettype none

module pulse_oximeter_beat_spo2_core #(
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pobs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pobs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [SAMPLE_BITS-1:0]            ir_sample,
    input  wire logic [SAMPLE_BITS-1:0]            red_sample,
    input  wire logic [31:0]                       time_ms,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             bpm,
    output logic [6:0]                             spo2,
    output logic                                   finger_present,
    output logic                                   beat,
    output logic                                   signal_lost,
    output logic signed [19:0]                     filtered_ir
);
    import pobs_pkg::*;

    cfg_t cfg_reg;

    logic                   q_valid;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_ir;
    logic [SAMPLE_BITS-1:0] q_red;
    logic [31:0]            q_time;
    logic                   q_present;

    // Register file: write only, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FINGER_LEVEL:      cfg_reg.finger_level      <= cfg_data;
                CFG_MIN_BEAT_INTERVAL: cfg_reg.min_beat_interval <= cfg_data[15:0];
                CFG_MAX_BEAT_INTERVAL: cfg_reg.max_beat_interval <= cfg_data[15:0];
                CFG_SIGNAL_TIMEOUT:    cfg_reg.signal_timeout    <= cfg_data[15:0];
                CFG_MIN_AC_SWING:      cfg_reg.min_ac_swing      <= cfg_data;
                CFG_SPO2_OFFSET:       cfg_reg.spo2_offset       <= cfg_data[7:0];
                CFG_SPO2_SLOPE:        cfg_reg.spo2_slope        <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: accept the item, mark finger presence, queue it
    pobs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .finger_level (cfg_reg.finger_level),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ir_sample    (ir_sample),
        .red_sample   (red_sample),
        .time_ms      (time_ms),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ir         (q_ir),
        .q_red        (q_red),
        .q_time       (q_time),
        .q_present    (q_present)
    );

    // Back: filters, beat logic, rate and SpO2, result register
    pobs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_ir           (q_ir),
        .q_red          (q_red),
        .q_time         (q_time),
        .q_present      (q_present),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bpm            (bpm),
        .spo2           (spo2),
        .finger_present (finger_present),
        .beat           (beat),
        .signal_lost    (signal_lost),
        .filtered_ir    (filtered_ir)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for pulse_oximeter_beat_spo2_core: drives optical sample items,
// predicts each result with an in-house fixed-point estimator and checks it.
// Depends on pobs_pkg and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pobs_pkg::*;

    localparam int F = 8;
    localparam longint ONE = 256;
    localparam longint KEEP_DC = 243;
    localparam longint KEEP_THR = 236;
    localparam longint KEEP_BPM = 179;
    localparam longint KEEP_SPO2 = 205;
    localparam longint PEAK0 = 64'sd99999 * 256;
    localparam longint LIMIT = 2000000;

    // Oximeter estimator: one result per sample pair
    class oximeter_board;
        cfg_t cfg;
        longint dc_ir, dc_red, prev_ir, prev_red;
        longint ir_hi, ir_lo, red_hi, red_lo, thr, bpm_q, spo2_q;
        bit latch;
        bit [31:0] last_beat, last_present;
        logic [7:0] q_bpm[$];
        logic [6:0] q_spo2[$];
        logic q_fp[$], q_beat[$], q_lost[$];
        logic [19:0] q_fir[$];
        int errors, beats, lost_seen, results;

        function new();
            cfg = CFG_RESET;
            dc_ir = 0; dc_red = 0; prev_ir = 0; prev_red = 0;
            clear_peaks();
            thr = 1500 * ONE; latch = 0; last_beat = 0; last_present = 0;
            bpm_q = 75 * ONE; spo2_q = 98 * ONE;
            errors = 0; beats = 0; lost_seen = 0; results = 0;
        endfunction

        function void clear_peaks();
            ir_hi = -PEAK0; ir_lo = PEAK0; red_hi = -PEAK0; red_lo = PEAK0;
        endfunction

        // >>> on signed longint floors, matching the model's floor shift
        function longint mix(longint old, longint fresh, longint keep);
            return (old * keep + fresh * (ONE - keep) + ONE / 2) >>> F;
        endfunction

        function longint chan(longint raw, ref longint dc, ref longint prev);
            longint x, ac;
            x = raw * ONE;
            dc = mix(dc, x, KEEP_DC);
            ac = ((x - dc) + prev) >>> 1;
            prev = ac;
            return ac;
        endfunction

        function void spo2_refresh();
            longint ia, ra, calc;
            longint unsigned num, den, q, r, ratio;
            ia = ir_hi - ir_lo;
            ra = red_hi - red_lo;
            if (!(ia > longint'(cfg.min_ac_swing) * ONE && ra > longint'(cfg.min_ac_swing) * ONE
                  && dc_ir > 0 && dc_red > 0))
                return;
            num = longint'(ra) * dc_ir;
            den = longint'(ia) * dc_red;
            if (den == 0)
                return;
            q = num / den;
            r = num % den;
            if (q >= 65536)
                ratio = 64'd1 << (16 + F);
            else
            begin
                ratio = q;
                for (int i = 0; i < F; i++)
                begin
                    r = r << 1;
                    ratio = ratio << 1;
                    if (r >= den)
                    begin
                        r -= den;
                        ratio |= 1;
                    end
                end
            end
            calc = longint'(cfg.spo2_offset) * ONE - longint'(cfg.spo2_slope) * longint'(ratio);
            if (calc > 100 * ONE) calc = 100 * ONE;
            if (calc < 70 * ONE) calc = 70 * ONE;
            spo2_q = mix(spo2_q, calc, KEEP_SPO2);
        endfunction

        function void note_sample(logic [17:0] ir, logic [17:0] red, logic [31:0] now);
            bit present, hit;
            longint ai, ar, mag, shown, rate;
            bit [31:0] gap;
            present = ir > cfg.finger_level;
            hit = 0;
            if (present) last_present = now;
            ai = chan(ir, dc_ir, prev_ir);
            ar = chan(red, dc_red, prev_red);
            if (present)
            begin
                if (ai > ir_hi) ir_hi = ai;
                if (ai < ir_lo) ir_lo = ai;
                if (ar > red_hi) red_hi = ar;
                if (ar < red_lo) red_lo = ar;
                if (ai > thr && !latch)
                begin
                    gap = now - last_beat;
                    latch = 1;
                    if (gap > cfg.min_beat_interval && gap < cfg.max_beat_interval)
                    begin
                        rate = (64'd60000 << F) / gap;
                        if (rate > 65535) rate = 65535;
                        bpm_q = mix(bpm_q, rate, KEEP_BPM);
                        hit = 1;
                        spo2_refresh();
                    end
                    last_beat = now;
                    clear_peaks();
                end
            end
            else
            begin
                latch = 0;
                bpm_q = 75 * ONE;
                spo2_q = 98 * ONE;
            end
            if (ai < thr) latch = 0;
            mag = ai < 0 ? -ai : ai;
            thr = mix(thr, mag, KEEP_THR);
            shown = ai >>> F;
            if (shown > 524287) shown = 524287;
            if (shown < -524288) shown = -524288;
            q_bpm.push_back(8'(bpm_q >>> F));
            q_spo2.push_back(7'(spo2_q >>> F));
            q_fp.push_back(present);
            q_beat.push_back(hit);
            q_lost.push_back((now - last_present) > cfg.signal_timeout);
            q_fir.push_back(20'(shown));
        endfunction

        function void check_result(logic [7:0] b, logic [6:0] s, logic fp, logic bt,
                                   logic sl, logic [19:0] fi);
            logic [7:0] eb;
            logic [6:0] es;
            logic efp, ebt, esl;
            logic [19:0] efi;
            results++;
            if (q_bpm.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result bpm=%0d spo2=%0d", b, s);
                return;
            end
            eb = q_bpm.pop_front(); es = q_spo2.pop_front(); efp = q_fp.pop_front();
            ebt = q_beat.pop_front(); esl = q_lost.pop_front(); efi = q_fir.pop_front();
            if (bt) beats++;
            if (sl) lost_seen++;
            if ({eb, es, efp, ebt, esl, efi} !== {b, s, fp, bt, sl, fi})
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch #%0d exp bpm=%0d spo2=%0d fp=%b beat=%b lost=%b ",
                              "fir=%0d | got bpm=%0d spo2=%0d fp=%b beat=%b lost=%b fir=%0d"},
                             results, eb, es, efp, ebt, esl, $signed(efi),
                             b, s, fp, bt, sl, $signed(fi));
            end
        endfunction

        function int pending();
            return q_bpm.size();
        endfunction
    endclass

    logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [17:0] ir_sample, red_sample;
    logic [31:0] time_ms;
    logic [7:0] bpm;
    logic [6:0] spo2;
    logic finger_present, beat, signal_lost;
    logic signed [19:0] filtered_ir;

    oximeter_board board;
    longint cycles;
    bit calm;          // when set, neither side idles
    bit [31:0] clock_ms;
    int sent;

    pulse_oximeter_beat_spo2_core uut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Watchdog: count cycles, give up at the limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample outputs at the rising edge, check each accepted result item
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(bpm, spo2, finger_present, beat, signal_lost, filtered_ir);

    // Receiver stall: random about 31 percent of cycles unless calm
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 31);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        case (idx)
            CFG_FINGER_LEVEL:      board.cfg.finger_level = val;
            CFG_MIN_BEAT_INTERVAL: board.cfg.min_beat_interval = val[15:0];
            CFG_MAX_BEAT_INTERVAL: board.cfg.max_beat_interval = val[15:0];
            CFG_SIGNAL_TIMEOUT:    board.cfg.signal_timeout = val[15:0];
            CFG_MIN_AC_SWING:      board.cfg.min_ac_swing = val;
            CFG_SPO2_OFFSET:       board.cfg.spo2_offset = val[7:0];
            default:               board.cfg.spo2_slope = val[7:0];
        endcase
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Drain: drop valid, wait for all results, then cover the back part's worst latency
    task automatic drain();
        in_valid <= 0;
        while (board.pending() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // Offer one sample item, hold it until accepted; valid stays up for a follow-on item
    task automatic send_sample(logic [17:0] ir, logic [17:0] red, logic [31:0] t);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1; ir_sample <= ir; red_sample <= red; time_ms <= t;
        do @(posedge clk); while (in_stall);
        board.note_sample(ir, red, t);
        sent++;
        @(negedge clk);
    endtask

    // Pulse waveform: rectangular swing around a DC level, high for a quarter of each period
    task automatic send_pulse_train(int n, int period_ms, int step_ms, int dc, int amp);
        int ph;
        for (int i = 0; i < n; i++)
        begin
            ph = (i * step_ms) % period_ms;
            clock_ms += step_ms;
            send_sample(18'(dc + (ph < period_ms / 4 ? amp : -amp / 3) + $urandom_range(40)),
                        18'(dc / 2 + (ph < period_ms / 4 ? amp / 2 : -amp / 6)
                            + $urandom_range(40)),
                        clock_ms);
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0; calm = 0; sent = 0; clock_ms = 0;
        rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; out_stall = 0; ir_sample = '0; red_sample = '0; time_ms = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: field extremes, no finger, wrap of time, timeout edge
        send_sample(18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF);
        send_sample(18'h0, 18'h0, 32'h0);
        send_sample(18'h3FFFF, 18'h0, 32'd5);
        send_sample(18'h0, 18'h3FFFF, 32'd2006);
        send_sample(18'd30000, 18'd100, 32'd4000);
        send_sample(18'd30001, 18'd100, 32'd4500);
        send_sample(18'h0, 18'h0, 32'd6500);
        send_sample(18'h0, 18'h0, 32'd6501);
        send_sample(18'h2AAAA, 18'h15555, 32'hAAAA_AAAA);
        send_sample(18'h15555, 18'h2AAAA, 32'h5555_5555);
        clock_ms = 32'd20000;
        send_pulse_train(15, 800, 20, 100000, 20000);

        // Pressure: sender holds off until every result is back
        drain();

        // Configuration phases with random pulses and noise; extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(CFG_FINGER_LEVEL, 18'd0); write_reg(CFG_MIN_BEAT_INTERVAL, 0);
                   write_reg(CFG_MAX_BEAT_INTERVAL, 16'hFFFF); write_reg(CFG_SIGNAL_TIMEOUT, 0);
                   write_reg(CFG_MIN_AC_SWING, 0); write_reg(CFG_SPO2_OFFSET, 8'hFF);
                   write_reg(CFG_SPO2_SLOPE, 0); end
                1: begin write_reg(CFG_FINGER_LEVEL, 18'h3FFFF);
                   write_reg(CFG_SIGNAL_TIMEOUT, 16'hFFFF);
                   write_reg(CFG_MIN_AC_SWING, 18'h3FFFF); write_reg(CFG_SPO2_SLOPE, 8'hFF); end
                2: begin write_reg(CFG_FINGER_LEVEL, 18'd30000); write_reg(CFG_MIN_BEAT_INTERVAL, 300);
                   write_reg(CFG_MAX_BEAT_INTERVAL, 2000); write_reg(CFG_SIGNAL_TIMEOUT, 2000);
                   write_reg(CFG_MIN_AC_SWING, 100); write_reg(CFG_SPO2_OFFSET, 110);
                   write_reg(CFG_SPO2_SLOPE, 25); calm = 1; end
                3: begin write_reg(CFG_SPO2_OFFSET, 0); write_reg(CFG_MIN_AC_SWING, 10);
                   calm = 0; end
                4: begin write_reg(CFG_SPO2_OFFSET, 140); write_reg(CFG_SPO2_SLOPE, 60);
                   write_reg(CFG_MIN_BEAT_INTERVAL, 16'hFFFF); end
                default: begin write_reg(CFG_MIN_BEAT_INTERVAL, 100);
                   write_reg(CFG_MAX_BEAT_INTERVAL, 3000); write_reg(CFG_SIGNAL_TIMEOUT, 50); end
            endcase
            for (int k = 0; k < 12; k++)
            begin
                case ($urandom_range(9))
                    0: send_sample(18'($urandom), 18'($urandom), $urandom);
                    1: begin
                        clock_ms += $urandom_range(3000);
                        send_sample(18'($urandom_range(20000)), 18'($urandom), clock_ms);
                    end
                    default: send_pulse_train(20, $urandom_range(300, 1500),
                                              $urandom_range(5, 60),
                                              $urandom_range(40000, 200000),
                                              $urandom_range(500, 50000));
                endcase
            end
        end

        drain();
        $display("covered %0d sample items, %0d accepted beats, %0d signal-lost results",
                 sent, board.beats, board.lost_seen);
        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", board.errors, board.pending());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
